/* design/window_median_filter_assert.svh */
// Assertion macros used by the checker file of the median filter.
// Each macro expands to one labeled concurrent assertion on clk, disabled in reset.
`ifndef WINDOW_MEDIAN_FILTER_ASSERT_SVH
`define WINDOW_MEDIAN_FILTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define WMF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define WMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/wmf_pkg.sv */
// ----------------------------------------------------------------------------
// wmf_pkg
// Shared widths, reset values and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package wmf_pkg;

    localparam int PIX_W = 8;
    localparam int SIDE_W = 4;
    localparam logic [SIDE_W-1:0] SIDE_RESET = 4'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic cfg_wr;    // load window side, drop the window in progress
        logic load_pix;  // capture the incoming pixel, start at the fill position
        logic rd_prev;   // read the entry below the insert position
        logic shift_wr;  // move the read entry up one slot
        logic place_wr;  // write the pixel at the insert position, count it
        logic rd_mid;    // read the middle entry of the sorted window
        logic load_out;  // load the output register from the read data
    } wmf_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic pos_zero;  // insert position is the bottom of the store
        logic prev_gt;   // entry read below the insert position is above the pixel
        logic last;      // the pixel being placed completes the window
    } wmf_status_t;

endpackage

`default_nettype wire

/* design/wmf_ctrl.sv */
// ----------------------------------------------------------------------------
// wmf_ctrl
// Sequencer for insertion into the sorted store, median readout and handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module wmf_ctrl
    import wmf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  wire wmf_status_t status,
    output wmf_cmd_t         cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_CMP  = 5'b00100,
        S_MED  = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Configuration wins over a pixel offered in the same idle cycle
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    cmd.cfg_wr = 1'b1;
                end
                else if (in_valid)
                begin
                    cmd.load_pix = 1'b1;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (status.pos_zero)
                begin
                    cmd.place_wr = 1'b1;
                    state_next   = status.last ? S_MED : S_IDLE;
                end
                else
                begin
                    cmd.rd_prev = 1'b1;
                    state_next  = S_CMP;
                end
            end
            S_CMP:
            begin
                if (status.prev_gt)
                begin
                    cmd.shift_wr = 1'b1;
                    state_next   = S_SCAN;
                end
                else
                begin
                    cmd.place_wr = 1'b1;
                    state_next   = status.last ? S_MED : S_IDLE;
                end
            end
            S_MED:
            begin
                cmd.rd_mid = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // Hold until the previous result has been taken
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, clear on transfer
    assign out_valid_next = cmd.load_out || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

/* design/wmf_datapath.sv */
// ----------------------------------------------------------------------------
// wmf_datapath
// Sorted pixel store, insert position, pixel count and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wmf_datapath
    import wmf_pkg::*;
#(
    parameter int MAX_SIDE = 15
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [PIX_W-1:0]  pixel_value,
    input  wire logic [SIDE_W-1:0] window_side,
    input  wire wmf_cmd_t          cmd,
    output wmf_status_t            status,
    output logic [PIX_W-1:0]       median_value
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int TW    = 2 * SW;

    logic [SIDE_W-1:0] side_reg;
    logic [SIDE_W-1:0] side_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [AW-1:0]     pos_reg;
    logic [AW-1:0]     pos_next;
    logic [PIX_W-1:0]  pix_reg;
    logic [PIX_W-1:0]  pix_next;
    logic [PIX_W-1:0]  rd_data_reg;
    logic [PIX_W-1:0]  median_reg;
    logic [PIX_W-1:0]  median_next;

    logic [SW-1:0]     eff_side;
    logic [TW-1:0]     total;
    logic [TW-1:0]     mid;
    logic              last;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [PIX_W-1:0]  wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;

    logic [PIX_W-1:0]  store_mem [DEPTH];

    // Clamp the side to 1..MAX_SIDE, derive window size and middle rank
    always_comb
    begin
        priority if (side_reg == '0)
        begin
            eff_side = SW'(1);
        end
        else if (int'(side_reg) > MAX_SIDE)
        begin
            eff_side = SW'(MAX_SIDE);
        end
        else
        begin
            eff_side = SW'(side_reg);
        end
    end

    assign total = TW'(eff_side) * TW'(eff_side);
    assign mid   = total >> 1;
    assign last  = (TW'(count_reg) + TW'(1)) == total;

    assign status.pos_zero = (pos_reg == '0);
    assign status.prev_gt  = (rd_data_reg > pix_reg);
    assign status.last     = last;

    // Store port selection
    assign wr_en   = cmd.shift_wr || cmd.place_wr;
    assign wr_addr = pos_reg;
    assign wr_data = cmd.shift_wr ? rd_data_reg : pix_reg;
    assign rd_en   = cmd.rd_prev || cmd.rd_mid;
    assign rd_addr = cmd.rd_mid ? mid[AW-1:0] : (pos_reg - AW'(1));

    // Sorted store, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // Next values of the control registers
    always_comb
    begin
        side_next  = side_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        if (cmd.cfg_wr)
        begin
            side_next  = window_side;
            count_next = '0;
        end
        if (cmd.load_pix)
        begin
            pos_next = count_reg[AW-1:0];
        end
        if (cmd.shift_wr)
        begin
            pos_next = pos_reg - AW'(1);
        end
        if (cmd.place_wr)
        begin
            count_next = last ? '0 : (count_reg + CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg  <= SIDE_RESET;
            count_reg <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            side_reg  <= side_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
        end
    end

    // Capture the pixel and the result
    assign pix_next    = cmd.load_pix ? pixel_value : pix_reg;
    assign median_next = cmd.load_out ? rd_data_reg : median_reg;

    always_ff @(posedge clk)
    begin
        pix_reg    <= pix_next;
        median_reg <= median_next;
    end

    assign median_value = median_reg;

endmodule

`default_nettype wire

/* design/window_median_filter.sv */
// Square-window median filter. Pixels of one window arrive in row-major order on the
// input channel; each is inserted into a single-port sorted store of MAX_SIDE squared
// bytes. After the last pixel of a window the entry at rank floor(side*side/2) appears
// on the output channel (for an even side, the upper of the two middle values). Each
// pixel is loaded while idle; each stored value above it then moves up one slot, and
// the pixel is written at the slot left free, or at the bottom of the store. The store's
// read data is registered, so each move is a read in S_SCAN and a compare and write in
// S_CMP, the state after it. After the last pixel of a window the middle entry is read,
// and the result waits in S_EMIT while an earlier result is still held in the output
// register. The output register lets the next window start while a result waits.
// A side of zero acts as one and a side above MAX_SIDE as MAX_SIDE; a side write drops
// the window in progress and is taken only while the block is idle.
// ----------------------------------------------------------------------------
// window_median_filter
// Top level: joins the insertion controller and the sorted-store datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module window_median_filter
    import wmf_pkg::*;
#(
    parameter int MAX_SIDE = 15
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [PIX_W-1:0]  pixel_value,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [PIX_W-1:0]       median_value,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [SIDE_W-1:0] window_side
);

    wmf_cmd_t    cmd;
    wmf_status_t status;

    // Sequencer
    wmf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Store and counters
    wmf_datapath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_value  (pixel_value),
        .window_side  (window_side),
        .cmd          (cmd),
        .status       (status),
        .median_value (median_value)
    );

endmodule

`default_nettype wire

/* design/wmf_checker.sv */
// ----------------------------------------------------------------------------
// wmf_checker
// Port-level checks of the median filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "window_median_filter_assert.svh"

module wmf_checker
    import wmf_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [PIX_W-1:0]  median_value,
    input wire logic              cfg_valid,
    input wire logic              cfg_ready
);

    // A stalled result holds its value
    `WMF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(median_value), "result dropped or changed while stalled")

    // A side write and a pixel never transfer together
    `WMF_ASSERT_SAME(a_cfg_excl, cfg_valid && cfg_ready, !(in_valid && in_ready), "pixel transfer during side write")

    // In the cycle after a pixel transfer the block is busy
    `WMF_ASSERT_NEXT(a_in_busy, in_valid && in_ready, !in_ready && !cfg_ready, "ready right after a pixel transfer")

    // A side write leaves the block idle and open to configuration
    `WMF_ASSERT_NEXT(a_cfg_idle, cfg_valid && cfg_ready, cfg_ready, "side write left the block busy")

endmodule

bind window_median_filter wmf_checker u_wmf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .median_value (median_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);

`default_nettype wire
